@@ hw/rtl/pulse_width_id_decoder_core_defines.svh @@
// Assertion macros used by the decoder core RTL.
`ifndef PULSE_WIDTH_ID_DECODER_CORE_DEFINES_SVH
`define PULSE_WIDTH_ID_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define PWID_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define PWID_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/pwid_pkg.sv @@
`default_nettype none

package pwid_pkg;

    // Field and register widths.
    localparam int CFG_W = 8;
    localparam int CFG_IDX_W = 2;
    localparam int RUN_W = 8;
    localparam int ID_W = 12;
    localparam int SYM_W = 2;

    // Default identifier length.
    localparam int ID_BITS_DEF = 12;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd2;

    // Register reset values.
    localparam logic [CFG_W-1:0] START_MIN_RST = 8'd10;
    localparam logic [CFG_W-1:0] ZERO_MAX_RST = 8'd4;
    localparam logic [CFG_W-1:0] WINDOW_LEN_RST = 8'd64;
    localparam logic [CFG_W-1:0] WINDOW_MIN = 8'd3;

    // Counter limits.
    localparam logic [RUN_W-1:0] RUN_SAT = 8'd255;
    localparam logic [RUN_W-1:0] NEVER_SEEN = 8'd255;
    localparam logic [1:0] SEEN_SAT = 2'd3;

    // Symbol codes.
    localparam logic [SYM_W-1:0] SYM_ZERO = 2'd0;
    localparam logic [SYM_W-1:0] SYM_ONE = 2'd1;
    localparam logic [SYM_W-1:0] SYM_START = 2'd2;

    // One completed pulse, as handed from the pulse unit to the framer.
    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] sym;
        logic [RUN_W-1:0] run;
    } pulse_t;

endpackage

`default_nettype wire

@@ hw/rtl/pwid_pulse_unit.sv @@
`default_nettype none

module pwid_pulse_unit
    import pwid_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             advance,
    input  wire logic             sample,
    input  wire logic [CFG_W-1:0] start_min,
    input  wire logic [CFG_W-1:0] zero_max,
    input  wire logic [CFG_W-1:0] win_eff,
    output pulse_t                pulse,
    output logic                  recently_seen
);

    logic [RUN_W-1:0] high_run_count_reg, high_run_count_next;
    logic             previous_sample_reg, previous_sample_next;
    logic [1:0]       samples_seen_reg, samples_seen_next;
    logic [RUN_W-1:0] since_last_high_reg, since_last_high_next;
    logic [RUN_W-1:0] run_cap;
    logic [RUN_W-1:0] run;
    logic             falling;

    // A falling edge counts once the third sample since reset has arrived.
    always_comb begin
        samples_seen_next = (samples_seen_reg == SEEN_SAT) ? SEEN_SAT
                                                           : samples_seen_reg + 2'd1;
        falling = !sample && previous_sample_reg && (samples_seen_next == SEEN_SAT);
    end

    // Cap the run at the window length minus one and classify it.
    always_comb begin
        run_cap = win_eff - 8'd1;
        run = (high_run_count_reg > run_cap) ? run_cap : high_run_count_reg;
        pulse.valid = advance && falling;
        pulse.run = falling ? run : '0;
        if (!falling) begin
            pulse.sym = SYM_ZERO;
        end else if (run >= start_min) begin
            pulse.sym = SYM_START;
        end else if (run <= zero_max) begin
            pulse.sym = SYM_ZERO;
        end else begin
            pulse.sym = SYM_ONE;
        end
    end

    // Run length and distance to the last high sample.
    always_comb begin
        previous_sample_next = sample;
        if (sample) begin
            high_run_count_next = (high_run_count_reg == RUN_SAT) ? RUN_SAT
                                                                  : high_run_count_reg + 8'd1;
            since_last_high_next = '0;
        end else begin
            high_run_count_next = '0;
            since_last_high_next = (since_last_high_reg == NEVER_SEEN)
                                   ? NEVER_SEEN : since_last_high_reg + 8'd1;
        end
        recently_seen = (since_last_high_next < win_eff);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_run_count_reg <= '0;
            previous_sample_reg <= 1'b0;
            samples_seen_reg <= '0;
            since_last_high_reg <= NEVER_SEEN;
        end else if (advance) begin
            high_run_count_reg <= high_run_count_next;
            previous_sample_reg <= previous_sample_next;
            samples_seen_reg <= samples_seen_next;
            since_last_high_reg <= since_last_high_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/pwid_framer.sv @@
`default_nettype none

module pwid_framer
    import pwid_pkg::*;
#(
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire pulse_t          pulse,
    output logic                 id_valid,
    output logic [ID_W-1:0]      id_value
);

    localparam int CNT_W = $clog2(ID_BITS + 2);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ID_BITS);
    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(ID_BITS + 1);

    logic             in_frame_reg, in_frame_next;
    logic [CNT_W-1:0] bit_count_reg, bit_count_next;
    logic [ID_W-1:0]  shift_reg, shift_next;

    // A start mark closes the open frame and opens the next one; data
    // bits shift in only inside a frame.
    always_comb begin
        in_frame_next = in_frame_reg;
        bit_count_next = bit_count_reg;
        shift_next = shift_reg;
        id_valid = 1'b0;
        id_value = '0;
        if (pulse.valid) begin
            if (pulse.sym == SYM_START) begin
                if (in_frame_reg && (bit_count_reg == CNT_FULL)) begin
                    id_valid = 1'b1;
                    id_value = shift_reg;
                end
                in_frame_next = 1'b1;
                bit_count_next = '0;
                shift_next = '0;
            end else if (in_frame_reg) begin
                shift_next = {shift_reg[ID_W-2:0], pulse.sym[0]};
                if (bit_count_reg != CNT_SAT) begin
                    bit_count_next = bit_count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            bit_count_reg <= '0;
            shift_reg <= '0;
        end else begin
            in_frame_reg <= in_frame_next;
            bit_count_reg <= bit_count_next;
            shift_reg <= shift_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/pulse_width_id_decoder_core.sv @@
// Pulse width identifier decoder.
// The input channel (s_valid, s_ready, s_sample) takes one light sample per
// item. The result channel (m_valid, m_ready, m_*) returns exactly one item
// per sample: the pulse that the sample completed, if any, its class and
// capped run length, a decoded identifier when a start mark closes a frame
// of ID_BITS data bits, and whether a high lies within the window.
// Thresholds and window length are written through cfg_we, cfg_index and
// cfg_wdata; the user must write them only while the block is idle, as the
// block does not enforce it. An index beyond the three registers is ignored.
// An accepted sample lands in an input register; when it advances, the
// classifier and framer run and their result is loaded into the result
// register. One item is taken every cycle as long as the receiver keeps up;
// the run counter and frame state update once per item.
// If the receiver stalls, the result register holds its item, one more
// sample waits in the input register, and s_ready then drops.
// Synchronous reset clears both registers, the pulse and frame state, and
// restores the register defaults (start 10, zero 4, window 64).
`default_nettype none

`include "pulse_width_id_decoder_core_defines.svh"

module pulse_width_id_decoder_core
    import pwid_pkg::*;
#(
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_sample,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_symbol_valid,
    output logic [SYM_W-1:0]          m_symbol,
    output logic [RUN_W-1:0]          m_high_run,
    output logic                      m_id_valid,
    output logic [ID_W-1:0]           m_id_value,
    output logic                      m_recently_seen
);

    logic [CFG_W-1:0] start_min_reg, zero_max_reg, window_len_reg;
    logic [CFG_W-1:0] win_eff;
    logic             in_valid_reg, in_valid_next;
    logic             in_sample_reg;
    logic             out_valid_reg, out_valid_next;
    logic             advance;
    logic             s_accept;
    pulse_t           pulse;
    logic             recently_seen;
    logic             id_valid;
    logic [ID_W-1:0]  id_value;
    logic             symbol_valid_reg;
    logic [SYM_W-1:0] symbol_reg;
    logic [RUN_W-1:0] high_run_reg;
    logic             id_valid_reg;
    logic [ID_W-1:0]  id_value_reg;
    logic             recently_seen_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_min_reg <= START_MIN_RST;
            zero_max_reg <= ZERO_MAX_RST;
            window_len_reg <= WINDOW_LEN_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_START_MIN:  start_min_reg <= cfg_wdata;
                REG_ZERO_MAX:   zero_max_reg <= cfg_wdata;
                REG_WINDOW_LEN: window_len_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Windows shorter than three act as three.
    assign win_eff = (window_len_reg < WINDOW_MIN) ? WINDOW_MIN : window_len_reg;

    // Handshake: an item moves on whenever the result register is free or drains.
    always_comb begin
        advance = in_valid_reg && (!out_valid_reg || m_ready);
        s_ready = !in_valid_reg || advance;
        s_accept = s_valid && s_ready;
        in_valid_next = s_accept || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_ready);
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_sample_reg <= s_sample;
        end
    end

    pwid_pulse_unit u_pulse (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .sample        (in_sample_reg),
        .start_min     (start_min_reg),
        .zero_max      (zero_max_reg),
        .win_eff       (win_eff),
        .pulse         (pulse),
        .recently_seen (recently_seen)
    );

    pwid_framer #(
        .ID_BITS (ID_BITS)
    ) u_framer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pulse    (pulse),
        .id_valid (id_valid),
        .id_value (id_value)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            symbol_valid_reg <= pulse.valid;
            symbol_reg <= pulse.sym;
            high_run_reg <= pulse.run;
            id_valid_reg <= id_valid;
            id_value_reg <= id_value;
            recently_seen_reg <= recently_seen;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_symbol_valid = symbol_valid_reg;
    assign m_symbol = symbol_reg;
    assign m_high_run = high_run_reg;
    assign m_id_valid = id_valid_reg;
    assign m_id_value = id_value_reg;
    assign m_recently_seen = recently_seen_reg;

    // An identifier only comes out with the start mark that closed its frame.
    `PWID_ASSERT_NOW(a_id_with_start, aclk, aresetn, m_valid && m_id_valid, m_symbol_valid && (m_symbol == SYM_START), "identifier without start mark")

    // Without a pulse the symbol fields are zero.
    `PWID_ASSERT_NOW(a_idle_symbol, aclk, aresetn, m_valid && !m_symbol_valid, (m_symbol == SYM_ZERO) && (m_high_run == '0) && !m_id_valid, "symbol fields set without a pulse")

    // The reported run never reaches the window length.
    `PWID_ASSERT_NOW(a_run_capped, aclk, aresetn, m_valid && m_symbol_valid, m_high_run < win_eff, "run length above window cap")

    // The input side stalls only when both registers are full and the receiver waits.
    `PWID_ASSERT_NOW(a_stall_cause, aclk, aresetn, !s_ready, in_valid_reg && out_valid_reg && !m_ready, "input stalled without backpressure")

    // A processed item always shows up in the result register.
    `PWID_ASSERT_NEXT(a_result_loaded, aclk, aresetn, advance, m_valid, "processed item lost")

endmodule

`default_nettype wire
